// File: rtl/lws_pkg.sv
// Shared constants, types and codes for the latency window statistics block.
// No dependencies; every other file but lws_ram imports this package.
package lws_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int DATA_W     = 64;
  localparam int EDGE_W     = 32;
  localparam int EDGE_COUNT = 5;
  localparam int BIN_COUNT  = 6;
  localparam int BIN_W      = 3;

  // serial datapath: DIGIT_W bits per cycle
  localparam int DIGIT_W = 2;
  localparam int DIGITS  = DATA_W / DIGIT_W;
  localparam int STEP_W  = $clog2(DIGITS);

  localparam int IN_W     = 2 * DATA_W;
  localparam int OUT_BITS = 5 * DATA_W + BIN_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = EDGE_W;

  localparam logic [EDGE_COUNT-1:0][EDGE_W-1:0] EDGE_RESET = {
    32'd5000, 32'd2000, 32'd1000, 32'd500, 32'd250
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_EDGE_ONE   = 3'd0,
    REG_BIN_EDGE_TWO   = 3'd1,
    REG_BIN_EDGE_THREE = 3'd2,
    REG_BIN_EDGE_FOUR  = 3'd3,
    REG_BIN_EDGE_FIVE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                  below_min;
    logic                  above_max;
    logic [EDGE_COUNT-1:0] below_edge;
  } scan_flags_t;

endpackage

// File: rtl/lws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module lws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/lws_scan.sv
// Digit-serial scan: latency subtraction, window sum update and all compares
// against min, max and bin edges, LSB digit first. Depends on lws_pkg.
module lws_scan (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  logic                                          go,
  input  logic [lws_pkg::DATA_W-1:0]                    t_start,
  input  logic [lws_pkg::DATA_W-1:0]                    t_end,
  input  logic [lws_pkg::DATA_W-1:0]                    old_sample,
  input  logic [lws_pkg::DATA_W-1:0]                    sum_in,
  input  logic [lws_pkg::DATA_W-1:0]                    min_in,
  input  logic [lws_pkg::DATA_W-1:0]                    max_in,
  input  logic [lws_pkg::EDGE_COUNT-1:0][lws_pkg::EDGE_W-1:0] edges,
  output logic                                          done,
  output logic [lws_pkg::DATA_W-1:0]                    latency,
  output logic [lws_pkg::DATA_W-1:0]                    sum_out,
  output lws_pkg::scan_flags_t                          flags
);
  import lws_pkg::*;

  logic                               busy;
  logic [STEP_W-1:0]                  step;
  logic [DATA_W-1:0]                  a_sr, b_sr, old_sr, sum_sr, min_sr, max_sr;
  logic [EDGE_COUNT-1:0][EDGE_W-1:0]  edge_sr;
  logic                               bor_lat, bor_sum, car_sum;

  logic                               bor_lat_next, bor_sum_next, car_sum_next;
  scan_flags_t                        flags_next;
  logic [DIGIT_W-1:0]                 lat_dig, sum_dig;
  logic                               lbit, tbit;

  always_comb begin
    bor_lat_next = bor_lat;
    bor_sum_next = bor_sum;
    car_sum_next = car_sum;
    flags_next   = flags;
    lat_dig      = '0;
    sum_dig      = '0;
    lbit         = 1'b0;
    tbit         = 1'b0;
    for (int k = 0; k < DIGIT_W; k++) begin
      // end - start
      lbit = b_sr[k] ^ a_sr[k] ^ bor_lat_next;
      bor_lat_next = (~b_sr[k] & a_sr[k]) | (~b_sr[k] & bor_lat_next) |
                     (a_sr[k] & bor_lat_next);
      // sum - old + latency
      tbit = sum_sr[k] ^ old_sr[k] ^ bor_sum_next;
      bor_sum_next = (~sum_sr[k] & old_sr[k]) | (~sum_sr[k] & bor_sum_next) |
                     (old_sr[k] & bor_sum_next);
      lat_dig[k] = lbit;
      sum_dig[k] = tbit ^ lbit ^ car_sum_next;
      car_sum_next = (tbit & lbit) | (tbit & car_sum_next) | (lbit & car_sum_next);
      // the most significant differing bit decides, so later digits overwrite
      if (lbit != min_sr[k]) flags_next.below_min = ~lbit;
      if (lbit != max_sr[k]) flags_next.above_max = lbit;
      for (int e = 0; e < EDGE_COUNT; e++) begin
        if (lbit != edge_sr[e][k]) flags_next.below_edge[e] = ~lbit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_sr <= t_start;
      b_sr <= t_end;
    end
    if (go) begin
      old_sr  <= old_sample;
      sum_sr  <= sum_in;
      min_sr  <= min_in;
      max_sr  <= max_in;
      edge_sr <= edges;
      bor_lat <= 1'b0;
      bor_sum <= 1'b0;
      car_sum <= 1'b0;
      flags   <= '0;
    end else if (busy) begin
      a_sr    <= a_sr >> DIGIT_W;
      b_sr    <= b_sr >> DIGIT_W;
      old_sr  <= old_sr >> DIGIT_W;
      sum_sr  <= sum_sr >> DIGIT_W;
      min_sr  <= min_sr >> DIGIT_W;
      max_sr  <= max_sr >> DIGIT_W;
      for (int e = 0; e < EDGE_COUNT; e++) begin
        edge_sr[e] <= edge_sr[e] >> DIGIT_W;
      end
      bor_lat <= bor_lat_next;
      bor_sum <= bor_sum_next;
      car_sum <= car_sum_next;
      flags   <= flags_next;
      latency <= {lat_dig, latency[DATA_W-1:DIGIT_W]};
      sum_out <= {sum_dig, sum_out[DATA_W-1:DIGIT_W]};
    end
  end

endmodule

// File: rtl/lws_divider.sv
// Restoring divider, DIGIT_W quotient bits per cycle, for the window average.
// Divides the 64-bit window sum by the fill count. Depends on lws_pkg.
module lws_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lws_pkg::DATA_W-1:0] dividend,
  input  logic [lws_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [lws_pkg::DATA_W-1:0] quotient
);
  import lws_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem;

  logic [CNT_W-1:0]  rem_next;
  logic [DATA_W-1:0] quo_next;
  logic [CNT_W:0]    trial;

  always_comb begin
    rem_next = rem;
    quo_next = quotient;
    trial    = '0;
    for (int k = 0; k < DIGIT_W; k++) begin
      trial    = {rem_next, quo_next[DATA_W-1]};
      quo_next = {quo_next[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_next    = CNT_W'(trial - {1'b0, div_q});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the dividend shifts out of the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      div_q    <= divisor;
      rem      <= '0;
    end else if (busy) begin
      quotient <= quo_next;
      rem      <= rem_next;
    end
  end

endmodule

// File: rtl/latency_window_statistics.sv
// Latency window statistics: from each (t_start, t_end) transfer the block
// derives the latency and reports window average, min, max and histogram bin.
//
// Input: s_tvalid/s_tready/s_tdata carry t_start (bits 63:0) and t_end
// (bits 127:64). Output: m_tvalid/m_tready/m_tdata carry one result per input.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write the five bin
// edges (index 0..4, 32 bits); cfg_ready is high out of reset, other indexes drop.
//
// Items are handled one at a time: s_tready drops after a transfer and returns
// only once the result has loaded into the output register. Each item passes
// through the accept cycle, one RAM read, the 2-bit-per-cycle serial scan (latency,
// sum, compares) and the 2-bit-per-cycle serial divider, the handoffs between
// them and one output load.
// The sample ring is a 1024 x 64 RAM; until it is full the replaced sample is taken
// as zero, because the fill count says whether the slot being replaced was ever written.
// Reset clears pointers, sums and bins, sets min to all ones, clears max and restores
// the edge defaults; no clearing pass is needed. While the receiver stalls, the finished
// result holds in the output register and the next item is accepted and processed;
// that item then waits for the output register before its result loads.
module latency_window_statistics (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lws_pkg::IN_W-1:0]      s_tdata,    // t_start, t_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // latency, window_average, min_latency, max_latency, bin_index, bin_count
  output logic [lws_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lws_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lws_pkg::*;

  state_t                            state, state_next;
  logic [EDGE_COUNT-1:0][EDGE_W-1:0] edges;
  logic [PTR_W-1:0]                  write_pointer;
  logic [CNT_W-1:0]                  filled_count;
  logic [DATA_W-1:0]                 running_sum;
  logic [DATA_W-1:0]                 lowest_seen;
  logic [DATA_W-1:0]                 highest_seen;
  logic [DATA_W-1:0]                 histogram_bins [BIN_COUNT];
  logic [BIN_W-1:0]                  bin_q;
  logic [DATA_W-1:0]                 bin_count_q;

  logic              accept, scan_go, commit, out_load;
  logic              ring_full;
  logic [DATA_W-1:0] ring_rd_data, old_sample;
  logic [CNT_W-1:0]  count_next;
  logic [BIN_W-1:0]  bin_sel;
  logic [DATA_W-1:0] bin_inc;

  logic              scan_done, div_done;
  logic [DATA_W-1:0] scan_latency, scan_sum, average;
  scan_flags_t       scan_flags;

  assign cfg_ready  = ~rst;
  assign ring_full  = (filled_count == CNT_W'(WINDOW_DEPTH));
  assign old_sample = ring_full ? ring_rd_data : '0;
  assign count_next = ring_full ? filled_count : filled_count + 1'b1;

  always_comb begin
    bin_sel = BIN_W'(EDGE_COUNT);
    for (int e = EDGE_COUNT - 1; e >= 0; e--) begin
      if (scan_flags.below_edge[e]) bin_sel = BIN_W'(e);
    end
  end
  assign bin_inc = histogram_bins[bin_sel] + 1'b1;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    scan_go    = 1'b0;
    commit     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = ~rst;
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        scan_go    = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          commit     = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edges <= EDGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIN_EDGE_ONE:   edges[0] <= cfg_data;
        REG_BIN_EDGE_TWO:   edges[1] <= cfg_data;
        REG_BIN_EDGE_THREE: edges[2] <= cfg_data;
        REG_BIN_EDGE_FOUR:  edges[3] <= cfg_data;
        REG_BIN_EDGE_FIVE:  edges[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      filled_count  <= '0;
      running_sum   <= '0;
      lowest_seen   <= '1;
      highest_seen  <= '0;
      for (int b = 0; b < BIN_COUNT; b++) begin
        histogram_bins[b] <= '0;
      end
    end else if (commit) begin
      write_pointer <= (write_pointer == PTR_W'(WINDOW_DEPTH - 1)) ? '0 :
                       write_pointer + 1'b1;
      filled_count  <= count_next;
      running_sum   <= scan_sum;
      if (scan_flags.below_min) lowest_seen  <= scan_latency;
      if (scan_flags.above_max) highest_seen <= scan_latency;
      histogram_bins[bin_sel] <= bin_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      bin_q       <= bin_sel;
      bin_count_q <= bin_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_W - OUT_BITS){1'b0}}, bin_count_q, bin_q, highest_seen,
                  lowest_seen, average, scan_latency};
    end
  end

  lws_ram #(
    .WIDTH(DATA_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (commit),
    .wr_addr(write_pointer),
    .wr_data(scan_latency),
    .rd_en  (accept),
    .rd_addr(write_pointer),
    .rd_data(ring_rd_data)
  );

  lws_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .go        (scan_go),
    .t_start   (s_tdata[DATA_W-1:0]),
    .t_end     (s_tdata[IN_W-1:DATA_W]),
    .old_sample(old_sample),
    .sum_in    (running_sum),
    .min_in    (lowest_seen),
    .max_in    (highest_seen),
    .edges     (edges),
    .done      (scan_done),
    .latency   (scan_latency),
    .sum_out   (scan_sum),
    .flags     (scan_flags)
  );

  lws_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (commit),
    .dividend(scan_sum),
    .divisor (count_next),
    .done    (div_done),
    .quotient(average)
  );

endmodule

// File: test/tb_latency_window_statistics.sv
// Self-checking testbench for latency_window_statistics: drives timestamp pairs and
// bin edge writes, and checks every result against an in-bench window/histogram model.
// Depends on lws_pkg and the latency_window_statistics RTL only.
module tb_latency_window_statistics;
  import lws_pkg::*;

  localparam int PHASES        = 8;
  // transfers per idle/stall phase
  localparam int PHASE_ITEMS   = 48;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  // packed so that latency lands in the low bits, as on m_tdata
  typedef struct packed {
    logic [DATA_W-1:0] bin_count;
    logic [BIN_W-1:0]  bin_index;
    logic [DATA_W-1:0] max_latency;
    logic [DATA_W-1:0] min_latency;
    logic [DATA_W-1:0] window_average;
    logic [DATA_W-1:0] latency;
  } stats_t;

  typedef struct {
    logic [DATA_W-1:0] t_start;
    logic [DATA_W-1:0] t_end;
    logic              typed;
    stats_t            stats;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state
  logic [EDGE_W-1:0] bin_edges_now [EDGE_COUNT];
  logic [DATA_W-1:0] ring_model [WINDOW_DEPTH];
  logic [DATA_W-1:0] bin_totals [BIN_COUNT];
  logic [DATA_W-1:0] window_sum;
  logic [DATA_W-1:0] lowest_lat;
  logic [DATA_W-1:0] highest_lat;
  int                ring_slot;
  int                ring_fill;

  stats_t   expected_stats [$];
  dir_row_t dir_rows [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       sender_gap_pct = 0;
  int       sink_stall_pct = 0;

  latency_window_statistics uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_stats.size());
      $display("** latency_window_statistics: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic stats_t predict_window_stats(input logic [DATA_W-1:0] t_start,
                                                  input logic [DATA_W-1:0] t_end);
    stats_t r;
    logic [DATA_W-1:0] lat;
    int bin;
    lat = t_end - t_start;
    window_sum = window_sum - ring_model[ring_slot] + lat;
    ring_model[ring_slot] = lat;
    ring_slot = (ring_slot + 1 >= WINDOW_DEPTH) ? 0 : ring_slot + 1;
    if (ring_fill < WINDOW_DEPTH) ring_fill++;
    if (lat < lowest_lat) lowest_lat = lat;
    if (lat > highest_lat) highest_lat = lat;
    // first edge the latency falls below wins, even when edges are out of order
    bin = EDGE_COUNT;
    for (int k = EDGE_COUNT - 1; k >= 0; k--) begin
      if (lat < {{(DATA_W-EDGE_W){1'b0}}, bin_edges_now[k]}) bin = k;
    end
    bin_totals[bin] = bin_totals[bin] + 64'd1;
    r.latency        = lat;
    r.window_average = window_sum / DATA_W'(ring_fill);
    r.min_latency    = lowest_lat;
    r.max_latency    = highest_lat;
    r.bin_index      = BIN_W'(bin);
    r.bin_count      = bin_totals[bin];
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h", fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = stats_t'(m_tdata[OUT_BITS-1:0]);
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: %h", got);
      end else begin
        want = expected_stats.pop_front();
        check_field("latency", want.latency, got.latency);
        check_field("window_average", want.window_average, got.window_average);
        check_field("min_latency", want.min_latency, got.min_latency);
        check_field("max_latency", want.max_latency, got.max_latency);
        check_field("bin_index", DATA_W'(want.bin_index), DATA_W'(got.bin_index));
        check_field("bin_count", want.bin_count, got.bin_count);
      end
    end
  end

  task automatic send_stamps(input logic [DATA_W-1:0] t_start,
                             input logic [DATA_W-1:0] t_end,
                             input logic typed, input stats_t typed_stats);
    stats_t r;
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t_end, t_start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_window_stats(t_start, t_end);
    expected_stats.push_back(typed ? typed_stats : r);
  endtask

  task automatic write_edge(input cfg_reg_t idx, input logic [EDGE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bin_edges_now[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the input until every result is back and the block takes input again
  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_stats.size() != 0 || !s_tready) @(posedge clk);
  endtask

  task automatic draw_stamps(output logic [DATA_W-1:0] t_start,
                             output logic [DATA_W-1:0] t_end);
    logic [DATA_W-1:0] lat;
    int pick;
    int k;
    t_start = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 40) begin
      k = $urandom_range(EDGE_COUNT - 1);
      lat = {{(DATA_W-EDGE_W){1'b0}}, bin_edges_now[k]} + DATA_W'($urandom_range(4)) - 64'd2;
    end else if (pick < 65) begin
      lat = DATA_W'($urandom_range(8000));
    end else if (pick < 80) begin
      lat = {$urandom, $urandom};
    end else if (pick < 90) begin
      // start after end: wraps to a huge latency
      lat = -DATA_W'($urandom_range(1000, 1));
    end else begin
      lat = {$urandom, $urandom} >> $urandom_range(31, 1);
    end
    t_end = t_start + lat;
  endtask

  task automatic load_phase_edges(input int phase);
    logic [EDGE_W-1:0] e [EDGE_COUNT];
    case (phase)
      1: begin
        foreach (e[k]) e[k] = '0;
        // indexes past the last edge must be dropped
        for (int k = EDGE_COUNT; k < (1 << CFG_IDX_W); k++) begin
          @(negedge clk);
          cfg_valid <= 1'b1;
          cfg_index <= CFG_IDX_W'(k);
          cfg_data  <= '1;
          @(posedge clk);
          while (!cfg_ready) @(posedge clk);
          @(negedge clk);
          cfg_valid <= 1'b0;
        end
      end
      2: foreach (e[k]) e[k] = '1;
      3, 7: begin
        e[0] = EDGE_W'($urandom_range(2000));
        for (int k = 1; k < EDGE_COUNT; k++) e[k] = e[k-1] + EDGE_W'($urandom_range(3000));
      end
      4: foreach (e[k]) e[k] = EDGE_W'($urandom_range(8000));
      5: foreach (e[k]) e[k] = EDGE_RESET[k];
      default: foreach (e[k]) e[k] = $urandom;
    endcase
    write_edge(REG_BIN_EDGE_ONE, e[0]);
    write_edge(REG_BIN_EDGE_TWO, e[1]);
    write_edge(REG_BIN_EDGE_THREE, e[2]);
    write_edge(REG_BIN_EDGE_FOUR, e[3]);
    write_edge(REG_BIN_EDGE_FIVE, e[4]);
  endtask

  initial begin
    logic [DATA_W-1:0] ts;
    logic [DATA_W-1:0] te;
    stats_t none;
    none = '0;
    foreach (bin_edges_now[k]) bin_edges_now[k] = EDGE_RESET[k];
    foreach (ring_model[k]) ring_model[k] = '0;
    foreach (bin_totals[k]) bin_totals[k] = '0;
    window_sum  = '0;
    lowest_lat  = '1;
    highest_lat = '0;
    ring_slot   = 0;
    ring_fill   = 0;

    // first rows follow from reset state alone
    dir_rows.push_back('{64'd0, 64'd0, 1'b1,
                         '{64'd1, 3'd0, 64'd0, 64'd0, 64'd0, 64'd0}});
    dir_rows.push_back('{64'd0, '1, 1'b1,
                         '{64'd1, BIN_W'(BIN_COUNT - 1), '1, 64'd0,
                           64'h7FFF_FFFF_FFFF_FFFF, '1}});
    dir_rows.push_back('{64'd1, 64'd0, 1'b0, none});
    dir_rows.push_back('{'1, '1, 1'b0, none});
    dir_rows.push_back('{'1, 64'd0, 1'b0, none});
    dir_rows.push_back('{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, none});
    dir_rows.push_back('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, none});
    dir_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, none});
    // both sides of each default edge
    for (int k = 0; k < EDGE_COUNT; k++) begin
      dir_rows.push_back('{64'd100, 64'd99 + 64'(EDGE_RESET[k]), 1'b0, none});
      dir_rows.push_back('{64'd100, 64'd100 + 64'(EDGE_RESET[k]), 1'b0, none});
    end
    dir_rows.push_back('{64'd0, 64'h0000_0000_FFFF_FFFF, 1'b0, none});
    dir_rows.push_back('{64'd0, 64'h0000_0001_0000_0000, 1'b0, none});

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_stamps(dir_rows[i].t_start, dir_rows[i].t_end, dir_rows[i].typed,
                  dir_rows[i].stats);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin sender_gap_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_gap_pct = 72; sink_stall_pct = 0;  end
        2: begin sender_gap_pct = 0;  sink_stall_pct = 72; end
        default: begin sender_gap_pct = 35; sink_stall_pct = 35; end
      endcase
      if (phase != 0) begin
        drain();
        load_phase_edges(phase);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        draw_stamps(ts, te);
        send_stamps(ts, te, 1'b0, none);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** latency_window_statistics: PASSED **");
    end else begin
      $display("** latency_window_statistics: FAILED **");
    end
    $finish;
  end

endmodule
